// File: hw/rtl/i2c_master_byte_engine_top_macros.svh
// Assertion macros shared by the RTL of the I2C master byte engine.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef I2C_MASTER_BYTE_ENGINE_TOP_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define MBE_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MBE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`define MBE_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);
`else
`define MBE_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define MBE_ASSERT_NEXT(lbl, ante, cons, msg)
`define MBE_ASSERT_ALWAYS(lbl, cond, msg)
`endif
`endif

// File: hw/rtl/i2cmbe_pkg.sv
// Types and constants of the I2C master byte engine.
// Depends on nothing; used by the top level.
`default_nettype none
package i2cmbe_pkg;

    typedef enum logic [4:0]
    {
        OP_IDLE  = 5'b00001,
        OP_START = 5'b00010,
        OP_STOP  = 5'b00100,
        OP_WRITE = 5'b01000,
        OP_READ  = 5'b10000
    } op_state_t;

    localparam logic [1:0] OPC_START = 2'd0;
    localparam logic [1:0] OPC_STOP  = 2'd1;
    localparam logic [1:0] OPC_WRITE = 2'd2;
    localparam logic [1:0] OPC_READ  = 2'd3;

    localparam logic [1:0] PHASE_0 = 2'd0;
    localparam logic [1:0] PHASE_1 = 2'd1;
    localparam logic [1:0] PHASE_2 = 2'd2;
    localparam logic [1:0] PHASE_3 = 2'd3;

    localparam int QIDX_W = 6;
    localparam int TICK_W = 16;
    localparam logic [QIDX_W-1:0] SHORT_QUARTERS = 6'd4;
    localparam logic [QIDX_W-1:0] BYTE_QUARTERS  = 6'd36;
    localparam logic [TICK_W-1:0] QUARTER_PERIOD_RESET = 16'd6;

endpackage
`default_nettype wire

// File: hw/rtl/i2cmbe_cmd_if.sv
// Command channel of the I2C master byte engine: valid, ready and one command word.
// Depends on nothing.
`default_nettype none
interface i2cmbe_cmd_if;
    logic       valid;
    logic       ready;
    logic       cmd_valid;
    logic [1:0] opcode;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;

    modport source (output valid, cmd_valid, opcode, tx_byte, send_ack, sda_in, input ready);
    modport sink (input valid, cmd_valid, opcode, tx_byte, send_ack, sda_in, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/i2cmbe_res_if.sv
// Result channel of the I2C master byte engine: valid, ready and one result word.
// Depends on nothing.
`default_nettype none
interface i2cmbe_res_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_received;

    modport source (output valid, scl_out, sda_out, busy_res, done_res, rx_byte,
                    ack_received, input ready);
    modport sink (input valid, scl_out, sda_out, busy_res, done_res, rx_byte,
                  ack_received, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/i2c_master_byte_engine_top.sv
// I2C master byte engine: each accepted word is one base tick of the bus timing.
// The state registers double as the result register that feeds the result channel.
// Uses i2cmbe_pkg, i2cmbe_cmd_if, i2cmbe_res_if and the assertion macro header.
//
// Usage: every word on the cmd channel advances the engine by one base tick. The
// word carries cmd_valid, opcode, tx_byte and send_ack, which are looked at only
// while the engine is idle, and the sampled SDA level. For each accepted word the
// res channel delivers exactly one word with the SCL and SDA drive levels, busy,
// a one-tick done pulse, the last received byte and the last acknowledge flag.
// The result of a word accepted at one edge is registered and valid after that
// edge. Throughput is one word per cycle while res does not stall, set by the
// single registered pass through the quarter counter and line logic. A word is
// accepted whenever the result register is empty or its word is being taken in
// the same cycle, so a stall on res holds cmd ready low and the state frozen.
// quarter_period is written by cfg_we with cfg_wdata; zero counts as one tick per
// quarter. Reset returns to idle, both lines released and quarter_period at six.
`default_nettype none
`include "i2c_master_byte_engine_top_macros.svh"
module i2c_master_byte_engine_top
    import i2cmbe_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    i2cmbe_cmd_if.sink             cmd,
    i2cmbe_res_if.source           res,
    input  wire logic              cfg_we,
    input  wire logic [TICK_W-1:0] cfg_wdata
);

    logic [TICK_W-1:0] quarter_period_reg;
    op_state_t         active_op_reg, active_op_next;
    logic [QIDX_W-1:0] quarter_index_reg, quarter_index_next;
    logic [TICK_W-1:0] tick_count_reg, tick_count_next;
    logic [7:0]        shift_byte_reg, shift_byte_next;
    logic              ack_choice_reg, ack_choice_next;
    logic              scl_level_reg, scl_level_next;
    logic              sda_level_reg, sda_level_next;
    logic              ack_flag_reg, ack_flag_next;
    logic [7:0]        rx_hold_reg, rx_hold_next;
    logic              done_reg, done_next;
    logic              out_valid_reg, out_valid_next;

    logic              accept;
    logic              enter;
    logic [TICK_W-1:0] period;
    logic [TICK_W-1:0] tick_inc;
    logic [QIDX_W-1:0] quarter_inc;
    logic [QIDX_W-1:0] op_len;
    logic [1:0]        phase;
    logic [2:0]        bit_sel;
    logic              data_slot;

    assign cmd.ready = !out_valid_reg || res.ready;
    assign accept    = cmd.valid && cmd.ready;

    assign period      = (quarter_period_reg == '0) ? TICK_W'(1) : quarter_period_reg;
    assign tick_inc    = tick_count_reg + TICK_W'(1);
    assign quarter_inc = quarter_index_reg + QIDX_W'(1);
    assign op_len      = (active_op_reg == OP_START || active_op_reg == OP_STOP)
                         ? SHORT_QUARTERS : BYTE_QUARTERS;

    assign phase     = quarter_index_next[1:0];
    assign bit_sel   = quarter_index_next[4:2];
    assign data_slot = !quarter_index_next[5];

    always_comb
    begin
        active_op_next     = active_op_reg;
        quarter_index_next = quarter_index_reg;
        tick_count_next    = tick_count_reg;
        shift_byte_next    = shift_byte_reg;
        ack_choice_next    = ack_choice_reg;
        rx_hold_next       = rx_hold_reg;
        done_next          = done_reg;
        enter              = 1'b0;
        if (accept)
        begin
            done_next = 1'b0;
            if (active_op_reg == OP_IDLE)
            begin
                if (cmd.cmd_valid)
                begin
                    quarter_index_next = '0;
                    tick_count_next    = '0;
                    enter              = 1'b1;
                    case (cmd.opcode)
                        OPC_START: active_op_next = OP_START;
                        OPC_STOP:  active_op_next = OP_STOP;
                        OPC_WRITE:
                        begin
                            active_op_next  = OP_WRITE;
                            shift_byte_next = cmd.tx_byte;
                        end
                        OPC_READ:
                        begin
                            active_op_next  = OP_READ;
                            shift_byte_next = '0;
                            ack_choice_next = cmd.send_ack;
                        end
                        default: active_op_next = OP_IDLE;
                    endcase
                end
            end
            else if (tick_inc >= period)
            begin
                tick_count_next = '0;
                if (quarter_inc >= op_len)
                begin
                    if (active_op_reg == OP_READ)
                    begin
                        rx_hold_next = shift_byte_reg;
                    end
                    active_op_next     = OP_IDLE;
                    quarter_index_next = '0;
                    done_next          = 1'b1;
                end
                else
                begin
                    quarter_index_next = quarter_inc;
                    enter              = 1'b1;
                end
            end
            else
            begin
                tick_count_next = tick_inc;
            end
        end
    end

    always_comb
    begin
        scl_level_next = scl_level_reg;
        sda_level_next = sda_level_reg;
        ack_flag_next  = ack_flag_reg;
        if (enter)
        begin
            case (active_op_next)
                OP_START:
                begin
                    case (phase)
                        PHASE_0: sda_level_next = 1'b1;
                        PHASE_1: scl_level_next = 1'b1;
                        PHASE_2: sda_level_next = 1'b0;
                        default: scl_level_next = 1'b0;
                    endcase
                end
                OP_STOP:
                begin
                    case (phase)
                        PHASE_0: scl_level_next = 1'b0;
                        PHASE_1: sda_level_next = 1'b0;
                        PHASE_2: scl_level_next = 1'b1;
                        default: sda_level_next = 1'b1;
                    endcase
                end
                OP_WRITE:
                begin
                    case (phase)
                        PHASE_0:
                        begin
                            if (!data_slot)
                            begin
                                sda_level_next = 1'b1;
                            end
                        end
                        PHASE_1:
                        begin
                            if (data_slot)
                            begin
                                sda_level_next = shift_byte_next[3'd7 - bit_sel];
                            end
                            else
                            begin
                                scl_level_next = 1'b1;
                            end
                        end
                        PHASE_2:
                        begin
                            if (data_slot)
                            begin
                                scl_level_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (!data_slot)
                            begin
                                ack_flag_next = !cmd.sda_in;
                            end
                            scl_level_next = 1'b0;
                        end
                    endcase
                end
                OP_READ:
                begin
                    case (phase)
                        PHASE_0:
                        begin
                            if (data_slot)
                            begin
                                sda_level_next = 1'b1;
                            end
                        end
                        PHASE_1:
                        begin
                            if (data_slot)
                            begin
                                scl_level_next = 1'b1;
                            end
                            else
                            begin
                                sda_level_next = !ack_choice_next;
                            end
                        end
                        PHASE_2:
                        begin
                            if (!data_slot)
                            begin
                                scl_level_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            scl_level_next = 1'b0;
                        end
                    endcase
                end
                default:
                begin
                    scl_level_next = scl_level_reg;
                end
            endcase
        end
    end

    // The read shift happens in the last quarter of each data bit.
    logic [7:0] shift_byte_final;
    always_comb
    begin
        shift_byte_final = shift_byte_next;
        if (enter && active_op_next == OP_READ && data_slot && phase == PHASE_3)
        begin
            shift_byte_final = {shift_byte_next[6:0], cmd.sda_in};
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quarter_period_reg <= QUARTER_PERIOD_RESET;
            active_op_reg      <= OP_IDLE;
            quarter_index_reg  <= '0;
            tick_count_reg     <= '0;
            shift_byte_reg     <= '0;
            ack_choice_reg     <= 1'b0;
            scl_level_reg      <= 1'b1;
            sda_level_reg      <= 1'b1;
            ack_flag_reg       <= 1'b0;
            rx_hold_reg        <= '0;
            done_reg           <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                quarter_period_reg <= cfg_wdata;
            end
            active_op_reg     <= active_op_next;
            quarter_index_reg <= quarter_index_next;
            tick_count_reg    <= tick_count_next;
            shift_byte_reg    <= shift_byte_final;
            ack_choice_reg    <= ack_choice_next;
            scl_level_reg     <= scl_level_next;
            sda_level_reg     <= sda_level_next;
            ack_flag_reg      <= ack_flag_next;
            rx_hold_reg       <= rx_hold_next;
            done_reg          <= done_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.scl_out      = scl_level_reg;
    assign res.sda_out      = sda_level_reg;
    assign res.busy_res     = (active_op_reg != OP_IDLE);
    assign res.done_res     = done_reg;
    assign res.rx_byte      = rx_hold_reg;
    assign res.ack_received = ack_flag_reg;

    `MBE_ASSERT_ALWAYS(a_op_onehot, $onehot(active_op_reg), "Engine state is not one-hot.")
    `MBE_ASSERT_IMPLIES(a_done_idle, done_reg, active_op_reg == OP_IDLE,
                        "Completion pulse while a command is still active.")
    `MBE_ASSERT_IMPLIES(a_short_len,
                        active_op_reg == OP_START || active_op_reg == OP_STOP,
                        quarter_index_reg < SHORT_QUARTERS,
                        "Start or stop ran past its fourth quarter.")
    `MBE_ASSERT_ALWAYS(a_byte_len, quarter_index_reg < BYTE_QUARTERS,
                       "Quarter index ran past the end of a byte command.")
    `MBE_ASSERT_NEXT(a_idle_stays, accept && active_op_reg == OP_IDLE && !cmd.cmd_valid,
                     active_op_reg == OP_IDLE && !done_reg,
                     "Engine left idle without a command.")

endmodule
`default_nettype wire
